// ===== rtl/pwcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Page write conflict detector: shared definitions
// Sizes, register indexes, port layouts and the structs that pass between
// the region walker and the core.
// ----------------------------------------------------------------------------
package pwcd_pkg;

    localparam int PAGES   = 4096;
    localparam int FIBERS  = 16;
    localparam int REGIONS = 3;

    localparam int PG_AW  = $clog2(PAGES);
    localparam int FIB_AW = (FIBERS > 1) ? $clog2(FIBERS) : 1;
    localparam int REG_IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    localparam int ADDR_W    = 64;
    localparam int PN_W      = 52;
    localparam int CNT_W     = 32;
    localparam int SHIFT_W   = 5;
    localparam int RCNT_W    = 2;
    localparam int FID_W     = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION0_BASE = 3'd2;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 184;

    typedef struct packed {
        logic [RCNT_W-1:0]              count;
        logic [SHIFT_W-1:0]             shift;
        logic [REGIONS-1:0][ADDR_W-1:0] base;
        logic [REGIONS-1:0][ADDR_W-1:0] limit;
    } t_walk_cfg;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [ADDR_W-1:0] gpage;
    } t_walk_res;

endpackage

// ===== rtl/page_write_conflict_detector_core.sv =====
// ----------------------------------------------------------------------------
// Page write conflict detector core
// Maps write faults to global pages, stamps tracked pages with a global
// clock and flags writes that are stale across a fiber park.
// ----------------------------------------------------------------------------
// After reset the version table is swept to zero, one entry a cycle; no
// transaction is accepted during the sweep, though configuration writes are.
// A park event goes through the park state and the done state to the output
// register. A write fault goes through the region walker, whose single 64-bit
// adder takes up to a span, low, high and accumulate step per configured region,
// followed by a table read and update for a tracked page. One transaction is
// worked on at a time; a finished result sits in the output register while the
// next transaction is accepted.
module page_write_conflict_detector_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pwcd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                      i_cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [63:0] address, [67:64] fiber_id, [68] fiber_active, [71:69] zero
    input  logic [pwcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] kind
    input  logic [0:0]                       s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [51:0] page_number, [52] tracked, [53] conflict, [117:54] stamp,
    // [149:118] conflict_total, [181:150] fault_total, [183:182] zero
    output logic [pwcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] foreign
    output logic [0:0]                       m_axis_tuser
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_WALK  = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_PARK  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [pwcd_pkg::RCNT_W-1:0]                     r_rcount;
    logic [pwcd_pkg::SHIFT_W-1:0]                    r_shift;
    logic [pwcd_pkg::REGIONS-1:0][pwcd_pkg::ADDR_W-1:0] r_base;
    logic [pwcd_pkg::REGIONS-1:0][pwcd_pkg::ADDR_W-1:0] r_limit;

    // transaction context
    logic                            r_kind;
    logic [pwcd_pkg::FID_W-1:0]      r_fid;
    logic                            r_active;
    logic [pwcd_pkg::ADDR_W-1:0]     r_gp;

    // state
    logic [pwcd_pkg::PG_AW-1:0]      r_clr;
    logic [63:0]                     r_clock;
    logic [63:0]                     r_park [pwcd_pkg::FIBERS];
    logic [pwcd_pkg::CNT_W-1:0]      r_conf_cnt;
    logic [pwcd_pkg::CNT_W-1:0]      r_fault_cnt;

    // result being built
    logic                            r_res_foreign;
    logic [pwcd_pkg::PN_W-1:0]       r_res_pn;
    logic                            r_res_tracked;
    logic                            r_res_conflict;
    logic [63:0]                     r_res_stamp;

    // output register
    logic                            r_out_valid;
    logic [pwcd_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic                            r_out_user;

    pwcd_pkg::t_walk_cfg             w_walk_cfg;
    pwcd_pkg::t_walk_res             w_walk;
    logic                            w_in_acc;
    logic                            w_fid_ok;
    logic                            w_tracked;
    logic                            w_conflict;
    logic                            w_out_free;
    logic [63:0]                     w_clock_inc;
    logic [63:0]                     w_ver;
    logic                            w_ram_we;
    logic [pwcd_pkg::PG_AW-1:0]      w_ram_waddr;
    logic [63:0]                     w_ram_wdata;
    logic [pwcd_pkg::CNT_W-1:0]      w_conf_inc;
    logic [pwcd_pkg::CNT_W-1:0]      w_fault_inc;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_walk_cfg.count = r_rcount;
    assign w_walk_cfg.shift = r_shift;
    assign w_walk_cfg.base  = r_base;
    assign w_walk_cfg.limit = r_limit;

    pwcd_region_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc && !s_axis_tuser[0]),
        .i_addr  (s_axis_tdata[63:0]),
        .i_cfg   (w_walk_cfg),
        .o_res   (w_walk)
    );

    pwcd_ram #(
        .WIDTH (64),
        .DEPTH (pwcd_pkg::PAGES)
    ) u_versions (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_gp[pwcd_pkg::PG_AW-1:0]),
        .o_rdata (w_ver)
    );

    assign w_fid_ok    = 32'(r_fid) < pwcd_pkg::FIBERS;
    assign w_tracked   = w_walk.gpage < 64'(pwcd_pkg::PAGES);
    assign w_clock_inc = r_clock + 64'd1;
    assign w_conflict  = r_active && w_fid_ok
                         && (w_ver > r_park[pwcd_pkg::FIB_AW'(r_fid)]);
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_conf_inc  = (r_conf_cnt == '1) ? r_conf_cnt : r_conf_cnt + 1'b1;
    assign w_fault_inc = (r_fault_cnt == '1) ? r_fault_cnt : r_fault_cnt + 1'b1;

    // table write: zero sweep after reset, version stamp on a tracked fault
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_gp[pwcd_pkg::PG_AW-1:0];
        w_ram_wdata = w_clock_inc;
        if (r_state == ST_CLEAR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr;
            w_ram_wdata = '0;
        end else if (r_state == ST_CHECK) begin
            w_ram_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == pwcd_pkg::PG_AW'(pwcd_pkg::PAGES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = s_axis_tuser[0] ? ST_PARK : ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_walk.done) begin
                    n_state = (w_walk.hit && w_tracked) ? ST_READ : ST_DONE;
                end
            end
            ST_READ:  n_state = ST_CHECK;
            ST_CHECK: n_state = ST_DONE;
            ST_PARK:  n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + pwcd_pkg::PG_AW'(1);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcount <= '0;
            r_shift  <= pwcd_pkg::SHIFT_MIN;
            r_base   <= '0;
            r_limit  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == pwcd_pkg::CFG_REGION_COUNT) begin
                r_rcount <= i_cfg_data[pwcd_pkg::RCNT_W-1:0];
            end
            if (i_cfg_index == pwcd_pkg::CFG_PAGE_SHIFT) begin
                r_shift <= i_cfg_data[pwcd_pkg::SHIFT_W-1:0];
            end
            for (int r = 0; r < pwcd_pkg::REGIONS; r++) begin
                if (i_cfg_index
                    == pwcd_pkg::CFG_IDX_W'(pwcd_pkg::CFG_REGION0_BASE + 2 * r)) begin
                    r_base[r] <= i_cfg_data;
                end
                if (i_cfg_index
                    == pwcd_pkg::CFG_IDX_W'(pwcd_pkg::CFG_REGION0_BASE + 2 * r + 1)) begin
                    r_limit[r] <= i_cfg_data;
                end
            end
        end
    end

    // clock, park clocks and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock     <= '0;
            r_conf_cnt  <= '0;
            r_fault_cnt <= '0;
            for (int f = 0; f < pwcd_pkg::FIBERS; f++) begin
                r_park[f] <= '0;
            end
        end else begin
            if (r_state == ST_WALK && w_walk.done && w_walk.hit && !w_tracked) begin
                r_fault_cnt <= w_fault_inc;
            end
            if (r_state == ST_CHECK) begin
                r_clock     <= w_clock_inc;
                r_fault_cnt <= w_fault_inc;
                if (w_conflict) begin
                    r_conf_cnt <= w_conf_inc;
                end
            end
            if (r_state == ST_PARK && r_rcount != '0 && w_fid_ok) begin
                r_park[pwcd_pkg::FIB_AW'(r_fid)] <= r_clock;
            end
        end
    end

    // transaction context and result fields
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind         <= s_axis_tuser[0];
            r_fid          <= s_axis_tdata[67:64];
            r_active       <= s_axis_tdata[68];
            r_res_foreign  <= 1'b0;
            r_res_pn       <= '0;
            r_res_tracked  <= 1'b0;
            r_res_conflict <= 1'b0;
            r_res_stamp    <= '0;
        end
        if (r_state == ST_WALK && w_walk.done) begin
            r_gp          <= w_walk.gpage;
            r_res_foreign <= !w_walk.hit;
            if (w_walk.hit) begin
                r_res_pn      <= w_walk.gpage[pwcd_pkg::PN_W-1:0];
                r_res_tracked <= w_tracked;
            end
        end
        if (r_state == ST_CHECK) begin
            r_res_conflict <= w_conflict;
            r_res_stamp    <= w_clock_inc;
        end
        if (r_state == ST_PARK && r_rcount != '0 && w_fid_ok) begin
            r_res_stamp <= r_clock;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_user <= r_res_foreign;
            r_out_data <= {2'b00, r_fault_cnt, r_conf_cnt, r_res_stamp,
                           r_res_conflict, r_res_tracked, r_res_pn};
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

    // a conflict is only ever raised on a tracked page
    a_conflict_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[53] && !m_axis_tdata[52]))
        else $error("conflict reported on an untracked page");

    // the fault counter never goes backwards
    a_fault_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> r_fault_cnt >= $past(r_fault_cnt))
        else $error("fault counter decreased");

    // the walker finishes only while the core waits for it
    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_walk.done |-> (r_state == ST_WALK && !r_kind))
        else $error("region walk finished outside a fault transaction");

endmodule

// ===== rtl/pwcd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pwcd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pwcd_region_walk.sv =====
// ----------------------------------------------------------------------------
// Region walker
// Maps a byte address to a global page number, one region after another,
// with a single 64-bit adder shared by every step.
// ----------------------------------------------------------------------------
module pwcd_region_walk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pwcd_pkg::ADDR_W-1:0] i_addr,
    input  pwcd_pkg::t_walk_cfg         i_cfg,
    output pwcd_pkg::t_walk_res         o_res
);

    typedef enum logic [3:0] {
        SP_SPAN = 4'b0001,
        SP_LOW  = 4'b0010,
        SP_HIGH = 4'b0100,
        SP_ACC  = 4'b1000
    } t_step;

    t_step                         r_step, n_step;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic                          r_hit, n_hit;
    logic [pwcd_pkg::REG_IW-1:0]   r_idx, n_idx;
    logic [pwcd_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [pwcd_pkg::ADDR_W-1:0]   r_acc, n_acc;
    logic [pwcd_pkg::ADDR_W-1:0]   r_span, n_span;
    logic [pwcd_pkg::ADDR_W-1:0]   r_off, n_off;

    logic [pwcd_pkg::SHIFT_W-1:0]  w_sh;
    logic [pwcd_pkg::RCNT_W-1:0]   w_n;
    logic                          w_last;
    logic [pwcd_pkg::ADDR_W-1:0]   w_op_a, w_op_b;
    logic                          w_sub;
    logic [pwcd_pkg::ADDR_W:0]     w_sum;
    logic                          w_carry;
    logic [pwcd_pkg::ADDR_W-1:0]   w_diff;

    // clamp page shift into its legal range
    always_comb begin
        if (i_cfg.shift < pwcd_pkg::SHIFT_MIN) begin
            w_sh = pwcd_pkg::SHIFT_MIN;
        end else if (i_cfg.shift > pwcd_pkg::SHIFT_MAX) begin
            w_sh = pwcd_pkg::SHIFT_MAX;
        end else begin
            w_sh = i_cfg.shift;
        end
    end

    assign w_n = (i_cfg.count > pwcd_pkg::RCNT_W'(pwcd_pkg::REGIONS))
                 ? pwcd_pkg::RCNT_W'(pwcd_pkg::REGIONS) : i_cfg.count;
    assign w_last = (3'(r_idx) + 3'd1) >= 3'(w_n);

    // operand select for the shared adder
    always_comb begin
        w_op_a = r_addr;
        w_op_b = i_cfg.base[r_idx];
        w_sub  = 1'b1;
        case (r_step)
            SP_SPAN: begin
                w_op_a = i_cfg.limit[r_idx];
                w_op_b = i_cfg.base[r_idx];
            end
            SP_LOW: begin
                w_op_b = i_cfg.base[r_idx];
            end
            SP_HIGH: begin
                w_op_b = i_cfg.limit[r_idx];
            end
            SP_ACC: begin
                w_op_a = r_acc;
                w_op_b = r_hit ? (r_off >> w_sh) : r_span;
                w_sub  = 1'b0;
            end
            default: begin
                w_sub = 1'b1;
            end
        endcase
    end

    assign w_sum   = {1'b0, w_op_a} + {1'b0, w_op_b ^ {pwcd_pkg::ADDR_W{w_sub}}}
                     + (pwcd_pkg::ADDR_W + 1)'(w_sub);
    assign w_carry = w_sum[pwcd_pkg::ADDR_W];
    assign w_diff  = w_sum[pwcd_pkg::ADDR_W-1:0];

    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        n_hit  = r_hit;
        n_idx  = r_idx;
        n_addr = r_addr;
        n_acc  = r_acc;
        n_span = r_span;
        n_off  = r_off;
        if (i_start) begin
            n_addr = i_addr;
            n_acc  = '0;
            n_idx  = '0;
            n_hit  = 1'b0;
            n_step = SP_SPAN;
            if (w_n == '0) begin
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            case (r_step)
                SP_SPAN: begin
                    // an empty or inverted region is skipped outright
                    if (!w_carry || w_diff == '0) begin
                        if (w_last) begin
                            n_done = 1'b1;
                            n_busy = 1'b0;
                        end else begin
                            n_idx = r_idx + pwcd_pkg::REG_IW'(1);
                        end
                    end else begin
                        n_span = w_diff >> w_sh;
                        n_step = SP_LOW;
                    end
                end
                SP_LOW: begin
                    if (!w_carry) begin
                        n_hit  = 1'b0;
                        n_step = SP_ACC;
                    end else begin
                        n_off  = w_diff;
                        n_step = SP_HIGH;
                    end
                end
                SP_HIGH: begin
                    n_hit  = !w_carry;
                    n_step = SP_ACC;
                end
                SP_ACC: begin
                    n_acc  = w_diff;
                    n_step = SP_SPAN;
                    if (r_hit || w_last) begin
                        n_done = 1'b1;
                        n_busy = 1'b0;
                    end else begin
                        n_idx = r_idx + pwcd_pkg::REG_IW'(1);
                    end
                end
                default: begin
                    n_step = SP_SPAN;
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= SP_SPAN;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
            r_done <= n_done;
            r_hit  <= n_hit;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_acc  <= n_acc;
        r_span <= n_span;
        r_off  <= n_off;
    end

    assign o_res.done  = r_done;
    assign o_res.hit   = r_hit;
    assign o_res.gpage = r_acc;

endmodule

// ===== tb/page_write_conflict_detector_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page write conflict detector core: self-checking testbench
// Drives write-fault and park transactions through the stream ports under
// several region layouts, predicts every result with an independent model of
// the page mapping, version table and counters, and compares each field.
// ----------------------------------------------------------------------------
module page_write_conflict_detector_core_tb;

    import pwcd_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 4;
    // covers the table sweep after reset plus many of the slowest transactions
    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 80;
    localparam int CALM_ITEMS    = 60;
    localparam int REPORT_MAX    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION0_LIMIT = CFG_REGION0_BASE + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION1_BASE  = CFG_REGION0_BASE + 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION1_LIMIT = CFG_REGION0_BASE + 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION2_BASE  = CFG_REGION0_BASE + 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION2_LIMIT = CFG_REGION0_BASE + 3'd5;

    localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

    typedef enum logic {
        EV_FAULT = 1'b0,
        EV_PARK  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_EVENT,
        ROW_TYPED
    } t_row_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] address;
        logic [FID_W-1:0]  fiber;
        logic              active;
    } t_event;

    typedef struct packed {
        logic              foreign;
        logic [PN_W-1:0]   page;
        logic              tracked;
        logic              conflict;
        logic [63:0]       stamp;
        logic [CNT_W-1:0]  conflicts;
        logic [CNT_W-1:0]  faults;
    } t_verdict;

    typedef struct {
        t_row_kind              op;
        logic [CFG_IDX_W-1:0]   idx;
        logic [63:0]            data;
        t_event                 ev;
        t_verdict               want;
    } t_row;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [63:0]             i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [0:0]              s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]              m_axis_tuser;

    page_write_conflict_detector_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // shadow of the configuration registers
    logic [RCNT_W-1:0]  sh_count = '0;
    logic [SHIFT_W-1:0] sh_shift = SHIFT_MIN;
    logic [63:0]        sh_base  [REGIONS];
    logic [63:0]        sh_limit [REGIONS];

    // predicted block state
    logic [63:0]        page_ver [PAGES];
    logic [63:0]        park_stamp [FIBERS];
    logic [63:0]        gclock;
    logic [CNT_W-1:0]   conflict_cnt;
    logic [CNT_W-1:0]   fault_cnt;

    t_verdict pending_verdicts [$];
    t_row     plan [$];

    int errors         = 0;
    int results_seen   = 0;
    int events_sent    = 0;
    int parks_sent     = 0;
    int foreign_seen   = 0;
    int untracked_seen = 0;
    int conflicts_seen = 0;
    int settings_used  = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    bit calm           = 1'b0;
    bit in_busy        = 1'b0;
    bit cfg_busy       = 1'b0;

    function automatic logic [SHIFT_W-1:0] eff_shift();
        if (sh_shift < SHIFT_MIN) return SHIFT_MIN;
        if (sh_shift > SHIFT_MAX) return SHIFT_MAX;
        return sh_shift;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        case (idx)
            CFG_REGION_COUNT:  sh_count    = data[RCNT_W-1:0];
            CFG_PAGE_SHIFT:    sh_shift    = data[SHIFT_W-1:0];
            CFG_REGION0_BASE:  sh_base[0]  = data;
            CFG_REGION0_LIMIT: sh_limit[0] = data;
            CFG_REGION1_BASE:  sh_base[1]  = data;
            CFG_REGION1_LIMIT: sh_limit[1] = data;
            CFG_REGION2_BASE:  sh_base[2]  = data;
            CFG_REGION2_LIMIT: sh_limit[2] = data;
            default: ;
        endcase
    endfunction

    // Work out the result of one transaction and advance the predicted state.
    function automatic t_verdict predict_event(t_event ev);
        t_verdict           v;
        logic [63:0]        acc;
        logic [63:0]        gp;
        logic [63:0]        lo;
        logic [63:0]        hi;
        logic               hit;
        int                 n;
        logic [SHIFT_W-1:0] sh;
        v   = '0;
        sh  = eff_shift();
        acc = '0;
        gp  = '0;
        hit = 1'b0;
        if (ev.kind == EV_PARK) begin
            if (sh_count != 0 && ev.fiber < FIBERS) begin
                park_stamp[ev.fiber] = gclock;
                v.stamp = gclock;
            end
        end else begin
            n = (sh_count > REGIONS) ? REGIONS : int'(sh_count);
            for (int r = 0; r < n; r++) begin
                lo = sh_base[r];
                hi = sh_limit[r];
                // an empty or inverted region neither matches nor adds pages
                if (!hit && hi > lo) begin
                    if (ev.address >= lo && ev.address < hi) begin
                        gp  = acc + ((ev.address - lo) >> sh);
                        hit = 1'b1;
                    end else begin
                        acc = acc + ((hi - lo) >> sh);
                    end
                end
            end
            if (!hit) begin
                v.foreign = 1'b1;
            end else begin
                v.page = gp[PN_W-1:0];
                if (gp < PAGES) begin
                    v.tracked = 1'b1;
                    if (ev.active && ev.fiber < FIBERS &&
                        page_ver[gp[PG_AW-1:0]] > park_stamp[ev.fiber]) begin
                        v.conflict = 1'b1;
                        if (conflict_cnt != '1) conflict_cnt = conflict_cnt + 1'b1;
                    end
                    gclock = gclock + 64'd1;
                    page_ver[gp[PG_AW-1:0]] = gclock;
                    v.stamp = gclock;
                end
                if (fault_cnt != '1) fault_cnt = fault_cnt + 1'b1;
            end
        end
        v.conflicts = conflict_cnt;
        v.faults    = fault_cnt;
        return v;
    endfunction

    // Mostly hit the first few pages of a region so that pages are rewritten
    // across parks; the rest lands anywhere, on the edges or outside.
    function automatic t_event random_event();
        t_event             ev;
        int                 r;
        int                 mode;
        logic [63:0]        lo;
        logic [63:0]        hi;
        logic [63:0]        span;
        logic [63:0]        off;
        logic [SHIFT_W-1:0] sh;
        ev.kind    = ($urandom_range(0, 3) == 0) ? EV_PARK : EV_FAULT;
        ev.fiber   = FID_W'($urandom_range(0, FIBERS - 1));
        ev.active  = ($urandom_range(0, 3) != 0);
        ev.address = {$urandom, $urandom};
        r    = $urandom_range(0, REGIONS - 1);
        lo   = sh_base[r];
        hi   = sh_limit[r];
        span = hi - lo;
        sh   = eff_shift();
        mode = $urandom_range(0, 19);
        if (hi > lo && mode < 11) begin
            off = (64'($urandom_range(0, 5)) << sh) +
                  (64'($urandom) & ((64'd1 << sh) - 64'd1));
            ev.address = lo + (off % span);
        end else if (hi > lo && mode < 14) begin
            ev.address = lo + ({$urandom, $urandom} % span);
        end else if (mode < 16) begin
            case ($urandom_range(0, 3))
                0:       ev.address = lo;
                1:       ev.address = hi - 64'd1;
                2:       ev.address = hi;
                default: ev.address = lo - 64'd1;
            endcase
        end
        return ev;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("mismatch on result %0d, %s: expected %h, got %h",
                         results_seen, name, want, got);
        end
    endfunction

    // Hold off the sender until every outstanding result has been taken.
    task automatic wait_idle();
        if (in_busy) begin
            s_axis_tvalid <= 1'b0;
            in_busy = 1'b0;
        end
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        cfg_busy = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    task automatic send_event(input t_event ev, input bit typed, input t_verdict want);
        t_verdict v;
        int       gap;
        if (cfg_busy) begin
            i_cfg_valid <= 1'b0;
            cfg_busy = 1'b0;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - ADDR_W - FID_W - 1){1'b0}},
                          ev.active, ev.fiber, ev.address};
        s_axis_tuser  <= ev.kind;
        in_busy = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        v = predict_event(ev);
        if (typed) v = want;
        pending_verdicts.push_back(v);
        events_sent++;
        if (ev.kind == EV_PARK) parks_sent++;
        if (v.foreign) foreign_seen++;
        if (ev.kind == EV_FAULT && !v.foreign && !v.tracked) untracked_seen++;
        if (v.conflict) conflicts_seen++;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            in_busy = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_layout(input int ph);
        logic [63:0]        lo;
        logic [63:0]        hi;
        logic [63:0]        junk;
        logic [RCNT_W-1:0]  cnt;
        logic [SHIFT_W-1:0] shv;
        logic [SHIFT_W-1:0] sh;
        int                 sel;
        logic [63:0]        pages;
        cnt = ($urandom_range(0, 7) == 0) ? '0 : RCNT_W'($urandom_range(1, REGIONS));
        if (ph == PHASES - 1) cnt = RCNT_W'(REGIONS);
        if (ph == 1)
            shv = SHIFT_MAX;
        else if (ph == 2)
            shv = SHIFT_MIN;
        else if ($urandom_range(0, 4) == 0)
            shv = SHIFT_W'($urandom_range(0, 31));
        else
            shv = SHIFT_W'($urandom_range(SHIFT_MIN, SHIFT_MAX));
        // upper bits of the narrow registers carry junk that must be dropped
        junk = {$urandom, $urandom};
        write_reg(CFG_REGION_COUNT, {junk[63:RCNT_W], cnt});
        junk = {$urandom, $urandom};
        write_reg(CFG_PAGE_SHIFT, {junk[63:SHIFT_W], shv});
        sh = eff_shift();
        for (int r = 0; r < REGIONS; r++) begin
            lo  = {$urandom, $urandom};
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                hi = lo - 64'($urandom_range(0, 64));
            end else begin
                pages = (sel == 1) ? 64'($urandom_range(4000, 6000))
                                   : 64'($urandom_range(1, 48));
                hi = lo + (pages << sh) + (64'($urandom) & ((64'd1 << sh) - 64'd1));
            end
            case (r)
                0: begin
                    write_reg(CFG_REGION0_BASE, lo);
                    write_reg(CFG_REGION0_LIMIT, hi);
                end
                1: begin
                    write_reg(CFG_REGION1_BASE, lo);
                    write_reg(CFG_REGION1_LIMIT, hi);
                end
                default: begin
                    write_reg(CFG_REGION2_BASE, lo);
                    write_reg(CFG_REGION2_LIMIT, hi);
                end
            endcase
        end
        settings_used++;
    endtask

    task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        t_row row;
        row      = '{op: ROW_CFG, idx: idx, data: data, ev: '0, want: '0};
        plan.push_back(row);
    endtask

    task automatic plan_event(input t_kind kind, input logic [63:0] addr,
                              input logic [FID_W-1:0] fid, input logic act,
                              input bit typed, input t_verdict want);
        t_row row;
        row.op   = typed ? ROW_TYPED : ROW_EVENT;
        row.idx  = '0;
        row.data = '0;
        row.ev   = {kind, addr, fid, act};
        row.want = want;
        plan.push_back(row);
    endtask

    // output side back-pressure: random stalls, none in the closing stretch
    always @(posedge i_clk) begin
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(1, 13);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("result %0d arrived with nothing outstanding", results_seen);
            end else begin
                want = pending_verdicts.pop_front();
                check_field("foreign", 64'(want.foreign), 64'(m_axis_tuser[0]));
                check_field("page_number", 64'(want.page), 64'(m_axis_tdata[51:0]));
                check_field("tracked", 64'(want.tracked), 64'(m_axis_tdata[52]));
                check_field("conflict", 64'(want.conflict), 64'(m_axis_tdata[53]));
                check_field("stamp", want.stamp, m_axis_tdata[117:54]);
                check_field("conflict_total", 64'(want.conflicts), 64'(m_axis_tdata[149:118]));
                check_field("fault_total", 64'(want.faults), 64'(m_axis_tdata[181:150]));
            end
        end
    end

    // end the run if no transaction of any kind moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", idle_cycles);
                $display("page_write_conflict_detector_core_tb: done, errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        t_row row;
        for (int r = 0; r < REGIONS; r++) begin
            sh_base[r]  = '0;
            sh_limit[r] = '0;
        end
        for (int p = 0; p < PAGES; p++) page_ver[p] = '0;
        for (int f = 0; f < FIBERS; f++) park_stamp[f] = '0;
        gclock       = '0;
        conflict_cnt = '0;
        fault_cnt    = '0;

        // Directed part. Typed verdicts: {foreign, page, tracked, conflict,
        // stamp, conflict_total, fault_total}.
        // block disabled after reset: faults are foreign, parks record nothing
        plan_event(EV_FAULT, 64'd0, 4'd0, 1'b1, 1'b1,
                   {1'b1, 52'd0, 1'b0, 1'b0, 64'd0, 32'd0, 32'd0});
        plan_event(EV_FAULT, ADDR_TOP, 4'd15, 1'b0, 1'b1,
                   {1'b1, 52'd0, 1'b0, 1'b0, 64'd0, 32'd0, 32'd0});
        plan_event(EV_PARK, 64'd0, 4'd15, 1'b1, 1'b1,
                   {1'b0, 52'd0, 1'b0, 1'b0, 64'd0, 32'd0, 32'd0});
        plan_event(EV_PARK, ADDR_TOP, 4'd0, 1'b0, 1'b1,
                   {1'b0, 52'd0, 1'b0, 1'b0, 64'd0, 32'd0, 32'd0});

        // three regions, the last one ending at the top of the address space
        plan_cfg(CFG_REGION_COUNT, 64'd3);
        plan_cfg(CFG_PAGE_SHIFT, 64'd12);
        plan_cfg(CFG_REGION0_BASE, 64'h1_0000);
        plan_cfg(CFG_REGION0_LIMIT, 64'h2_0000);
        plan_cfg(CFG_REGION1_BASE, 64'h1_0000_0000);
        plan_cfg(CFG_REGION1_LIMIT, 64'h1_0000_8000);
        plan_cfg(CFG_REGION2_BASE, 64'hFFFF_FFFF_FFFF_0000);
        plan_cfg(CFG_REGION2_LIMIT, ADDR_TOP);
        plan_event(EV_FAULT, 64'h1_0000, 4'd1, 1'b1, 1'b1,
                   {1'b0, 52'd0, 1'b1, 1'b0, 64'd1, 32'd0, 32'd1});
        plan_event(EV_PARK, 64'd0, 4'd1, 1'b1, 1'b1,
                   {1'b0, 52'd0, 1'b0, 1'b0, 64'd1, 32'd0, 32'd1});
        plan_event(EV_FAULT, 64'h1_0010, 4'd2, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, 64'h1_0FFF, 4'd1, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, 64'h1_0800, 4'd3, 1'b0, 1'b0, '0);
        plan_event(EV_FAULT, 64'h1_FFFF, 4'd4, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, 64'h2_0000, 4'd5, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, 64'h0_FFFF, 4'd6, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, 64'h1_0000_0000, 4'd7, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, 64'hFFFF_FFFF_FFFF_FFFE, 4'd8, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, ADDR_TOP, 4'd9, 1'b1, 1'b0, '0);

        // shift above range, one region spanning nearly everything, an
        // inverted second region
        plan_cfg(CFG_REGION_COUNT, 64'd2);
        plan_cfg(CFG_PAGE_SHIFT, 64'd31);
        plan_cfg(CFG_REGION0_BASE, 64'd0);
        plan_cfg(CFG_REGION0_LIMIT, ADDR_TOP);
        plan_cfg(CFG_REGION1_BASE, ADDR_TOP);
        plan_cfg(CFG_REGION1_LIMIT, 64'd0);
        plan_event(EV_FAULT, 64'd0, 4'd10, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, 64'hFFFF_FFFF_FFFF_FFFE, 4'd11, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, ADDR_TOP, 4'd12, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, 64'h5_0000, 4'd13, 1'b1, 1'b0, '0);
        plan_event(EV_PARK, 64'd0, 4'd13, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, 64'h5_1234, 4'd13, 1'b1, 1'b0, '0);
        plan_event(EV_FAULT, 64'h5_FFFF, 4'd14, 1'b1, 1'b0, '0);

        // shift below range, empty region
        plan_cfg(CFG_REGION_COUNT, 64'd1);
        plan_cfg(CFG_PAGE_SHIFT, 64'd0);
        plan_cfg(CFG_REGION0_BASE, 64'h8000);
        plan_cfg(CFG_REGION0_LIMIT, 64'h8000);
        plan_event(EV_FAULT, 64'h8000, 4'd0, 1'b1, 1'b0, '0);
        plan_event(EV_PARK, 64'd0, 4'd15, 1'b1, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < plan.size(); k++) begin
            row = plan[k];
            case (row.op)
                ROW_CFG:   write_reg(row.idx, row.data);
                ROW_TYPED: send_event(row.ev, 1'b1, row.want);
                default:   send_event(row.ev, 1'b0, '0);
            endcase
        end
        settings_used += 4;

        for (int ph = 0; ph < PHASES; ph++) begin
            random_layout(ph);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == PHASES - 1 && k >= PHASE_ITEMS - CALM_ITEMS) calm = 1'b1;
                if (!calm && $urandom_range(0, 39) == 0) wait_idle();
                send_event(random_event(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            errors += pending_verdicts.size();
            $display("%0d results never arrived", pending_verdicts.size());
        end
        $display("Sent %0d transactions (%0d parks) across %0d register settings.",
                 events_sent, parks_sent, settings_used);
        $display("Results: %0d checked, %0d foreign, %0d untracked, %0d conflicts, %0d errors.",
                 results_seen, foreign_seen, untracked_seen, conflicts_seen, errors);
        if (errors == 0) begin
            $display("page_write_conflict_detector_core_tb: done, clean");
        end else begin
            $display("page_write_conflict_detector_core_tb: done, errors");
        end
        $finish;
    end

endmodule
